// ----- hw/rtl/frustum_box_cull_test_core_assert.svh -----
// Assertion macros shared by the frustum culling checker.
`ifndef FRUSTUM_BOX_CULL_TEST_CORE_ASSERT_SVH
`define FRUSTUM_BOX_CULL_TEST_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define FBC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define FBC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/fbc_pkg.sv -----
// ----------------------------------------------------------------------------
// fbc_pkg
// Shared types and constants of the frustum box culling core.
// ----------------------------------------------------------------------------
package fbc_pkg;

  localparam int PLANE_COUNT = 6;
  localparam int AXIS_COUNT  = 3;
  localparam int FIELD_W     = 32;
  localparam int FRAC_BITS   = 16;
  localparam int IDX_W       = 3;

  typedef enum logic {
    OP_PLANE_WRITE = 1'b0,
    OP_BOX_TEST    = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    VERDICT_INSIDE    = 2'd0,
    VERDICT_INTERSECT = 2'd1,
    VERDICT_OUTSIDE   = 2'd2
  } verdict_t;

endpackage

// ----- hw/rtl/fbc_if.sv -----
// ----------------------------------------------------------------------------
// fbc_cmd_if / fbc_res_if
// Valid/ready channels for commands and culling results.
// ----------------------------------------------------------------------------
interface fbc_cmd_if import fbc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      op;
  logic [IDX_W-1:0]          plane_index;
  logic signed [FIELD_W-1:0] normal_x;
  logic signed [FIELD_W-1:0] normal_y;
  logic signed [FIELD_W-1:0] normal_z;
  logic signed [FIELD_W-1:0] plane_offset;
  logic signed [FIELD_W-1:0] box_min_x;
  logic signed [FIELD_W-1:0] box_min_y;
  logic signed [FIELD_W-1:0] box_min_z;
  logic signed [FIELD_W-1:0] box_max_x;
  logic signed [FIELD_W-1:0] box_max_y;
  logic signed [FIELD_W-1:0] box_max_z;

  modport source (
    output valid, op, plane_index, normal_x, normal_y, normal_z, plane_offset,
           box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
    input  ready
  );
  modport sink (
    input  valid, op, plane_index, normal_x, normal_y, normal_z, plane_offset,
           box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
    output ready
  );
endinterface

interface fbc_res_if import fbc_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] verdict;
  logic       visible;

  modport source (output valid, verdict, visible, input ready);
  modport sink (input valid, verdict, visible, output ready);
endinterface

// ----- hw/rtl/frustum_box_cull_test_core.sv -----
// A box test passes the product, sum, sign and verdict registers; a stall can hold it.
// Throughput: one transaction per cycle unless stalled; four multiply/add stages set it.
// A plane write takes effect for the next transaction and yields no result.
// Stages advance independently, so bubbles collapse while the output waits.
// Reset (rst, synchronous): all planes zero, all stage valids clear.
// ----------------------------------------------------------------------------
// frustum_box_cull_test_core
// Six-plane frustum test of axis-aligned boxes by positive/negative corner.
// ----------------------------------------------------------------------------
module frustum_box_cull_test_core
  import fbc_pkg::*;
#(
  parameter int COORD_BITS = 32
) (
  input  logic      clk,
  input  logic      rst,
  fbc_cmd_if.sink   cmd,
  fbc_res_if.source res
);

  localparam int CoordW = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
  localparam int ProdW  = 2 * CoordW;
  localparam int DistW  = ProdW + 2;
  localparam int OffW   = CoordW + FRAC_BITS;

  logic signed [CoordW-1:0] nrm [PLANE_COUNT][AXIS_COUNT];
  logic signed [CoordW-1:0] ofs [PLANE_COUNT];

  logic signed [CoordW-1:0] bmin [AXIS_COUNT];
  logic signed [CoordW-1:0] bmax [AXIS_COUNT];
  logic signed [ProdW-1:0]  prod_pos_next [PLANE_COUNT][AXIS_COUNT];
  logic signed [ProdW-1:0]  prod_neg_next [PLANE_COUNT][AXIS_COUNT];

  logic                     v1, v2, v3, v4;
  logic                     rdy1, rdy2, rdy3, rdy4;
  logic signed [ProdW-1:0]  prod_pos [PLANE_COUNT][AXIS_COUNT];
  logic signed [ProdW-1:0]  prod_neg [PLANE_COUNT][AXIS_COUNT];
  logic signed [CoordW-1:0] ofs1 [PLANE_COUNT];
  logic signed [DistW-1:0]  pos_a [PLANE_COUNT];
  logic signed [DistW-1:0]  pos_b [PLANE_COUNT];
  logic signed [DistW-1:0]  neg_a [PLANE_COUNT];
  logic signed [DistW-1:0]  neg_b [PLANE_COUNT];
  logic [PLANE_COUNT-1:0]   pos_neg;
  logic [PLANE_COUNT-1:0]   neg_neg;
  verdict_t                 verdict;
  logic                     visible;
  logic                     plane_wr;

  assign rdy4      = !v4 || res.ready;
  assign rdy3      = !v3 || rdy4;
  assign rdy2      = !v2 || rdy3;
  assign rdy1      = !v1 || rdy2;
  assign cmd.ready = rdy1;

  assign plane_wr = cmd.valid && rdy1 && (op_t'(cmd.op) == OP_PLANE_WRITE) &&
                    (cmd.plane_index < IDX_W'(PLANE_COUNT));

  function automatic logic signed [DistW-1:0] ext_prod(input logic signed [ProdW-1:0] p);
    ext_prod = {{(DistW-ProdW){p[ProdW-1]}}, p};
  endfunction

  function automatic logic signed [DistW-1:0] ext_ofs(input logic signed [CoordW-1:0] o);
    ext_ofs = {{(DistW-OffW){o[CoordW-1]}}, o, {FRAC_BITS{1'b0}}};
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < PLANE_COUNT; p++) begin
        for (int a = 0; a < AXIS_COUNT; a++) begin
          nrm[p][a] <= '0;
        end
        ofs[p] <= '0;
      end
    end else if (plane_wr) begin
      for (int p = 0; p < PLANE_COUNT; p++) begin
        if (cmd.plane_index == IDX_W'(p)) begin
          nrm[p][0] <= cmd.normal_x[CoordW-1:0];
          nrm[p][1] <= cmd.normal_y[CoordW-1:0];
          nrm[p][2] <= cmd.normal_z[CoordW-1:0];
          ofs[p]    <= cmd.plane_offset[CoordW-1:0];
        end
      end
    end
  end

  always_comb begin
    bmin[0] = cmd.box_min_x[CoordW-1:0];
    bmin[1] = cmd.box_min_y[CoordW-1:0];
    bmin[2] = cmd.box_min_z[CoordW-1:0];
    bmax[0] = cmd.box_max_x[CoordW-1:0];
    bmax[1] = cmd.box_max_y[CoordW-1:0];
    bmax[2] = cmd.box_max_z[CoordW-1:0];
    for (int p = 0; p < PLANE_COUNT; p++) begin
      for (int a = 0; a < AXIS_COUNT; a++) begin
        if (nrm[p][a][CoordW-1]) begin
          prod_pos_next[p][a] = nrm[p][a] * bmin[a];
          prod_neg_next[p][a] = nrm[p][a] * bmax[a];
        end else begin
          prod_pos_next[p][a] = nrm[p][a] * bmax[a];
          prod_neg_next[p][a] = nrm[p][a] * bmin[a];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= cmd.valid && (op_t'(cmd.op) == OP_BOX_TEST);
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
      if (rdy4) begin
        v4 <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      prod_pos <= prod_pos_next;
      prod_neg <= prod_neg_next;
      ofs1     <= ofs;
    end
    if (rdy2) begin
      for (int p = 0; p < PLANE_COUNT; p++) begin
        pos_a[p] <= ext_prod(prod_pos[p][0]) + ext_prod(prod_pos[p][1]);
        pos_b[p] <= ext_prod(prod_pos[p][2]) + ext_ofs(ofs1[p]);
        neg_a[p] <= ext_prod(prod_neg[p][0]) + ext_prod(prod_neg[p][1]);
        neg_b[p] <= ext_prod(prod_neg[p][2]) + ext_ofs(ofs1[p]);
      end
    end
    if (rdy3) begin
      for (int p = 0; p < PLANE_COUNT; p++) begin
        pos_neg[p] <= (pos_a[p] + pos_b[p]) < 0;
        neg_neg[p] <= (neg_a[p] + neg_b[p]) < 0;
      end
    end
    if (rdy4) begin
      if (|pos_neg) begin
        verdict <= VERDICT_OUTSIDE;
        visible <= 1'b0;
      end else if (|neg_neg) begin
        verdict <= VERDICT_INTERSECT;
        visible <= 1'b1;
      end else begin
        verdict <= VERDICT_INSIDE;
        visible <= 1'b1;
      end
    end
  end

  assign res.valid   = v4;
  assign res.verdict = verdict;
  assign res.visible = visible;

endmodule

// ----- hw/rtl/fbc_checker.sv -----
// ----------------------------------------------------------------------------
// fbc_checker
// Port-level checks of the frustum culling core, bound to the top level.
// ----------------------------------------------------------------------------
`include "frustum_box_cull_test_core_assert.svh"

module fbc_checker
  import fbc_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input logic [1:0] res_verdict,
  input logic       res_visible
);

  `FBC_ASSERT_NOW(a_visible_match, res_valid, res_visible == (res_verdict != VERDICT_OUTSIDE), "visible disagrees with verdict")
  `FBC_ASSERT_NOW(a_verdict_code, res_valid, res_verdict != 2'd3, "verdict code out of range")
  `FBC_ASSERT_NOW(a_reset_empty, $past(rst), !res_valid, "result valid right after reset")
  `FBC_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_verdict) && $stable(res_visible), "stalled result changed")

endmodule

bind frustum_box_cull_test_core fbc_checker u_fbc_checker (
  .clk         (clk),
  .rst         (rst),
  .res_valid   (res.valid),
  .res_ready   (res.ready),
  .res_verdict (res.verdict),
  .res_visible (res.visible)
);

// ----- tb/sv/frustum_box_cull_test_core_test.sv -----
// ----------------------------------------------------------------------------
// frustum_box_cull_test_core_test
// Self-checking bench for the six-plane frustum box culling core. A table of
// plane writes and box tests runs first, then randomized scene traffic: whole
// frustum rewrites, boxes around the view volume, and raw full-range noise.
// Expected verdicts come from typed rows or an exact 66-bit plane-distance model.
// Both channels idle in random bursts outside the steady tail; the result side
// holds off once for a long stretch so the pipeline backs up to the command side.
// ----------------------------------------------------------------------------
module frustum_box_cull_test_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fbc_pkg::*;

  localparam int COORD_BITS   = 32;
  localparam int RANDOM_ITEMS = 1320;
  localparam int STEADY_ITEMS = 200;
  localparam int REFRAME_GAP  = 60;
  localparam int LONG_HOLD    = 120;
  localparam int Q_ONE_I      = 65536;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    op_t                op;
    logic [2:0]         plane_index;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
    logic signed [31:0] plane_offset;
    logic signed [31:0] box_min_x;
    logic signed [31:0] box_min_y;
    logic signed [31:0] box_min_z;
    logic signed [31:0] box_max_x;
    logic signed [31:0] box_max_y;
    logic signed [31:0] box_max_z;
  } cull_cmd_t;

  typedef struct packed {
    verdict_t verdict;
    logic     visible;
  } cull_verdict_t;

  typedef struct packed {
    cull_cmd_t item;
    logic      typed;
    verdict_t  verdict;
  } directed_row_t;

  logic clk;
  logic rst;

  fbc_cmd_if cmd_ch ();
  fbc_res_if res_ch ();

  frustum_box_cull_test_core #(
    .COORD_BITS(COORD_BITS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .res(res_ch)
  );

  logic signed [31:0] frustum_nx [PLANE_COUNT];
  logic signed [31:0] frustum_ny [PLANE_COUNT];
  logic signed [31:0] frustum_nz [PLANE_COUNT];
  logic signed [31:0] frustum_off [PLANE_COUNT];

  cull_verdict_t verdict_queue [$];
  int            fault_count;
  int            verdicts_checked;
  logic          steady_phase;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400_000;
    $display("frustum_box_cull_test_core_test: FAIL");
    $finish;
  end

  function automatic logic signed [31:0] qfix(int v);
    return 32'(v) <<< 16;
  endfunction

  function automatic logic signed [31:0] coord_of(logic [31:0] raw);
    int w;
    w = (COORD_BITS < 32) ? COORD_BITS : 32;
    return $signed(raw << (32 - w)) >>> (32 - w);
  endfunction

  function automatic logic below_plane(int k, logic signed [31:0] x,
                                       logic signed [31:0] y, logic signed [31:0] z);
    logic signed [65:0] nx, ny, nz, off, cx, cy, cz, plane_dist;
    nx         = frustum_nx[k];
    ny         = frustum_ny[k];
    nz         = frustum_nz[k];
    off        = frustum_off[k];
    cx         = x;
    cy         = y;
    cz         = z;
    plane_dist = nx * cx + ny * cy + nz * cz + (off <<< 16);
    return plane_dist[65];
  endfunction

  function automatic cull_verdict_t classify_box(cull_cmd_t it);
    logic signed [31:0] lo [3];
    logic signed [31:0] hi [3];
    logic               outside, crossing, gx, gy, gz;
    cull_verdict_t      r;
    lo[0]    = coord_of(it.box_min_x);
    lo[1]    = coord_of(it.box_min_y);
    lo[2]    = coord_of(it.box_min_z);
    hi[0]    = coord_of(it.box_max_x);
    hi[1]    = coord_of(it.box_max_y);
    hi[2]    = coord_of(it.box_max_z);
    outside  = 1'b0;
    crossing = 1'b0;
    for (int k = 0; k < PLANE_COUNT; k++) begin
      gx = !frustum_nx[k][31];
      gy = !frustum_ny[k][31];
      gz = !frustum_nz[k][31];
      if (below_plane(k, gx ? hi[0] : lo[0], gy ? hi[1] : lo[1], gz ? hi[2] : lo[2]))
        outside = 1'b1;
      if (below_plane(k, gx ? lo[0] : hi[0], gy ? lo[1] : hi[1], gz ? lo[2] : hi[2]))
        crossing = 1'b1;
    end
    if (outside) begin
      r.verdict = VERDICT_OUTSIDE;
      r.visible = 1'b0;
    end else begin
      r.verdict = crossing ? VERDICT_INTERSECT : VERDICT_INSIDE;
      r.visible = 1'b1;
    end
    return r;
  endfunction

  function automatic void load_plane(cull_cmd_t it);
    if (it.plane_index < PLANE_COUNT) begin
      frustum_nx[it.plane_index]  = coord_of(it.normal_x);
      frustum_ny[it.plane_index]  = coord_of(it.normal_y);
      frustum_nz[it.plane_index]  = coord_of(it.normal_z);
      frustum_off[it.plane_index] = coord_of(it.plane_offset);
    end
  endfunction

  function automatic cull_cmd_t noise_item();
    cull_cmd_t it;
    it.op           = op_t'($urandom_range(0, 1));
    it.plane_index  = 3'($urandom_range(0, 7));
    it.normal_x     = $urandom;
    it.normal_y     = $urandom;
    it.normal_z     = $urandom;
    it.plane_offset = $urandom;
    it.box_min_x    = $urandom;
    it.box_min_y    = $urandom;
    it.box_min_z    = $urandom;
    it.box_max_x    = $urandom;
    it.box_max_y    = $urandom;
    it.box_max_z    = $urandom;
    return it;
  endfunction

  function automatic cull_cmd_t frustum_plane(int k);
    cull_cmd_t          it;
    logic signed [31:0] comp [3];
    int                 axis;
    it = noise_item();
    it.op          = OP_PLANE_WRITE;
    it.plane_index = 3'(k);
    axis           = k / 2;
    for (int a = 0; a < 3; a++)
      comp[a] = 32'(int'($urandom_range(0, 16384)) - 8192);
    comp[axis] = 32'(int'($urandom_range(Q_ONE_I / 2, Q_ONE_I)));
    if (k % 2 == 1)
      comp[axis] = -comp[axis];
    it.normal_x     = comp[0];
    it.normal_y     = comp[1];
    it.normal_z     = comp[2];
    it.plane_offset = 32'(int'($urandom_range(Q_ONE_I, 64 * Q_ONE_I)));
    return it;
  endfunction

  function automatic cull_cmd_t scene_box();
    cull_cmd_t          it;
    logic signed [31:0] lo [3];
    logic signed [31:0] hi [3];
    logic signed [31:0] tmp;
    int                 c, h, a;
    it = noise_item();
    it.op = OP_BOX_TEST;
    for (int i = 0; i < 3; i++) begin
      c     = int'($urandom_range(0, 160 * Q_ONE_I)) - 80 * Q_ONE_I;
      h     = int'($urandom_range(0, 16 * Q_ONE_I));
      lo[i] = 32'(c - h);
      hi[i] = 32'(c + h);
    end
    if ($urandom_range(0, 19) == 0) begin
      a      = $urandom_range(0, 2);
      tmp    = lo[a];
      lo[a]  = hi[a];
      hi[a]  = tmp;
    end
    it.box_min_x = lo[0];
    it.box_min_y = lo[1];
    it.box_min_z = lo[2];
    it.box_max_x = hi[0];
    it.box_max_y = hi[1];
    it.box_max_z = hi[2];
    return it;
  endfunction

  function automatic directed_row_t plane_row(int idx, logic signed [31:0] nx,
                                              logic signed [31:0] ny,
                                              logic signed [31:0] nz,
                                              logic signed [31:0] off);
    directed_row_t r;
    r.item              = '0;
    r.item.op           = OP_PLANE_WRITE;
    r.item.plane_index  = 3'(idx);
    r.item.normal_x     = nx;
    r.item.normal_y     = ny;
    r.item.normal_z     = nz;
    r.item.plane_offset = off;
    r.typed             = 1'b0;
    r.verdict           = VERDICT_INSIDE;
    return r;
  endfunction

  function automatic directed_row_t box_row(logic typed, verdict_t v,
                                            logic signed [31:0] mnx, logic signed [31:0] mny,
                                            logic signed [31:0] mnz, logic signed [31:0] mxx,
                                            logic signed [31:0] mxy, logic signed [31:0] mxz);
    directed_row_t r;
    r.item           = '0;
    r.item.op        = OP_BOX_TEST;
    r.item.box_min_x = mnx;
    r.item.box_min_y = mny;
    r.item.box_min_z = mnz;
    r.item.box_max_x = mxx;
    r.item.box_max_y = mxy;
    r.item.box_max_z = mxz;
    r.typed          = typed;
    r.verdict        = v;
    return r;
  endfunction

  task automatic issue(cull_cmd_t it, logic typed, verdict_t typed_verdict);
    cull_verdict_t want;
    cmd_ch.valid        <= 1'b1;
    cmd_ch.op           <= it.op;
    cmd_ch.plane_index  <= it.plane_index;
    cmd_ch.normal_x     <= it.normal_x;
    cmd_ch.normal_y     <= it.normal_y;
    cmd_ch.normal_z     <= it.normal_z;
    cmd_ch.plane_offset <= it.plane_offset;
    cmd_ch.box_min_x    <= it.box_min_x;
    cmd_ch.box_min_y    <= it.box_min_y;
    cmd_ch.box_min_z    <= it.box_min_z;
    cmd_ch.box_max_x    <= it.box_max_x;
    cmd_ch.box_max_y    <= it.box_max_y;
    cmd_ch.box_max_z    <= it.box_max_z;
    do @(posedge clk); while (!cmd_ch.ready);
    if (it.op == OP_BOX_TEST) begin
      if (typed) begin
        want.verdict = typed_verdict;
        want.visible = (typed_verdict != VERDICT_OUTSIDE);
      end else begin
        want = classify_box(it);
      end
      verdict_queue.push_back(want);
    end else begin
      load_plane(it);
    end
    if (!steady_phase && $urandom_range(0, 5) == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  task automatic reframe();
    for (int k = 0; k < PLANE_COUNT; k++)
      issue(frustum_plane(k), 1'b0, VERDICT_INSIDE);
  endtask

  initial begin : result_sink
    int stall_left;
    logic long_hold_done;
    stall_left     = 0;
    long_hold_done = 1'b0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else if (!long_hold_done && verdicts_checked >= 150) begin
        long_hold_done = 1'b1;
        stall_left     = LONG_HOLD - 1;
        res_ch.ready <= 1'b0;
      end else if (!rst && !steady_phase && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 8);
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    cull_verdict_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (verdict_queue.size() == 0) begin
        $error("unexpected result: verdict %0d visible %0b", res_ch.verdict, res_ch.visible);
        fault_count++;
      end else begin
        want = verdict_queue.pop_front();
        verdicts_checked++;
        if (res_ch.verdict !== want.verdict) begin
          $error("verdict: expected %0d, got %0d", want.verdict, res_ch.verdict);
          fault_count++;
        end
        if (res_ch.visible !== want.visible) begin
          $error("visible: expected %0b, got %0b", want.visible, res_ch.visible);
          fault_count++;
        end
      end
    end
  end

  initial begin : stimulus
    directed_row_t directed_rows [$];
    int            pick;
    cull_cmd_t     it;
    fault_count      = 0;
    verdicts_checked = 0;
    steady_phase     = 1'b0;
    for (int k = 0; k < PLANE_COUNT; k++) begin
      frustum_nx[k]  = '0;
      frustum_ny[k]  = '0;
      frustum_nz[k]  = '0;
      frustum_off[k] = '0;
    end
    rst <= 1'b1;
    cmd_ch.valid        <= 1'b0;
    cmd_ch.op           <= OP_PLANE_WRITE;
    cmd_ch.plane_index  <= '0;
    cmd_ch.normal_x     <= '0;
    cmd_ch.normal_y     <= '0;
    cmd_ch.normal_z     <= '0;
    cmd_ch.plane_offset <= '0;
    cmd_ch.box_min_x    <= '0;
    cmd_ch.box_min_y    <= '0;
    cmd_ch.box_min_z    <= '0;
    cmd_ch.box_max_x    <= '0;
    cmd_ch.box_max_y    <= '0;
    cmd_ch.box_max_z    <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    directed_rows = '{
      box_row(1'b1, VERDICT_INSIDE, '0, '0, '0, '0, '0, '0),
      box_row(1'b1, VERDICT_INSIDE, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX),
      box_row(1'b1, VERDICT_INSIDE, Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN),
      plane_row(0, qfix(1), '0, '0, '0),
      box_row(1'b1, VERDICT_OUTSIDE, qfix(-2), qfix(-2), qfix(-2),
              qfix(-1), qfix(-1), qfix(-1)),
      box_row(1'b1, VERDICT_INTERSECT, qfix(-1), qfix(-1), qfix(-1),
              qfix(1), qfix(1), qfix(1)),
      box_row(1'b1, VERDICT_INSIDE, qfix(1), qfix(1), qfix(1), qfix(2), qfix(2), qfix(2)),
      box_row(1'b1, VERDICT_INSIDE, '0, '0, '0, '0, '0, '0),
      plane_row(6, qfix(-1), '0, '0, qfix(-100)),
      plane_row(7, qfix(-1), qfix(-1), qfix(-1), Q_MIN),
      box_row(1'b1, VERDICT_INSIDE, qfix(1), qfix(1), qfix(1), qfix(2), qfix(2), qfix(2)),
      box_row(1'b1, VERDICT_OUTSIDE, qfix(2), '0, '0, qfix(-2), '0, '0),
      plane_row(1, Q_MIN, Q_MIN, Q_MIN, Q_MAX),
      plane_row(2, Q_MAX, Q_MAX, Q_MAX, Q_MIN),
      box_row(1'b0, VERDICT_INSIDE, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX),
      box_row(1'b0, VERDICT_INSIDE, Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN),
      plane_row(3, '0, qfix(1), '0, qfix(5)),
      plane_row(4, '0, '0, qfix(-1), qfix(7)),
      plane_row(5, qfix(-1), qfix(-1), qfix(1), Q_MAX),
      box_row(1'b0, VERDICT_INSIDE, qfix(1), qfix(-3), qfix(-2), qfix(3), qfix(4), qfix(6)),
      box_row(1'b0, VERDICT_INSIDE, qfix(-9), qfix(-9), qfix(5), qfix(-4), qfix(-6), qfix(9)),
      plane_row(0, '0, '0, '0, '0),
      box_row(1'b0, VERDICT_INSIDE, qfix(-1), qfix(-1), qfix(-1), qfix(1), qfix(1), qfix(1)),
      box_row(1'b0, VERDICT_INSIDE, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX)
    };
    foreach (directed_rows[i])
      issue(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].verdict);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady_phase = (n >= RANDOM_ITEMS - STEADY_ITEMS);
      if (n % REFRAME_GAP == 0)
        reframe();
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        it = scene_box();
      end else if (pick < 77) begin
        it = frustum_plane($urandom_range(0, PLANE_COUNT - 1));
      end else if (pick < 79) begin
        it    = noise_item();
        it.op = OP_PLANE_WRITE;
      end else begin
        it    = noise_item();
        it.op = OP_BOX_TEST;
      end
      issue(it, 1'b0, VERDICT_INSIDE);
    end
    cmd_ch.valid <= 1'b0;

    while (verdict_queue.size() != 0)
      @(posedge clk);
    repeat (16) @(posedge clk);
    if (fault_count == 0)
      $display("frustum_box_cull_test_core_test: PASS");
    else
      $display("frustum_box_cull_test_core_test: FAIL");
    $finish;
  end

endmodule
